[hdl/three_button_debounce_chord_decoder_defines.svh]
// Assertion macros shared by the checker of the three-button debounce chord decoder.
`ifndef THREE_BUTTON_DEBOUNCE_CHORD_DECODER_DEFINES_SVH
`define THREE_BUTTON_DEBOUNCE_CHORD_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define TBDCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbdcd: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define TBDCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbdcd: next-cycle check failed");

`endif

[hdl/tbdcd_pkg.sv]
// Package with types and constants of the three-button debounce chord decoder.
package tbdcd_pkg;

    // Default width of each debounce counter.
    localparam int COUNTER_BITS_DEF = 8;

    // Width and reset value of the debounce threshold register.
    localparam int TICKS_W = 8;
    localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 8'd10;

    // Button lanes.
    localparam int BTN_POWER = 0;
    localparam int BTN_PLUS  = 1;
    localparam int BTN_MINUS = 2;
    localparam int BTN_COUNT = 3;

    // Button levels are active low.
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // Power state encoding.
    typedef enum logic [1:0] {
        PWR_OFF     = 2'd0,
        PWR_PRE_ON  = 2'd1,
        PWR_ON      = 2'd2,
        PWR_PRE_OFF = 2'd3
    } pwr_t;

    // Input word.
    typedef struct packed {
        logic       raw_power_button;
        logic       raw_plus_button;
        logic       raw_minus_button;
        logic [1:0] power_in;
    } tbdcd_in_t;

    // Output word.
    typedef struct packed {
        logic       bright_up;
        logic       bright_down;
        logic       colour_next;
        logic       output_next;
        logic [1:0] power_out;
    } tbdcd_out_t;

    // What one debounce lane reports to the merge stage.
    typedef struct packed {
        logic level;   // debounced level after this tick
        logic prev;    // debounced level after the previous tick
    } lane_stat_t;

endpackage

[hdl/tbdcd_lane.sv]
// One button debounce lane: saturating stable counter, candidate and debounced level.
module tbdcd_lane
    import tbdcd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               raw,
    input  logic [TICKS_W-1:0] ticks,
    output lane_stat_t         stat
);

    localparam int CMP_W = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;

    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic                    cand_reg, cand_next;
    logic                    deb_reg, deb_next;
    logic [COUNTER_BITS-1:0] cnt_base, cnt_inc;
    logic                    differs;
    logic                    adopt;

    // Restart on a raw change, count while the raw level differs from the debounced level, adopt at the threshold.
    always_comb
    begin
        cnt_base  = (raw != cand_reg) ? '0 : cnt_reg;
        cand_next = raw;
        differs   = (raw != deb_reg);
        cnt_inc   = (cnt_base != '1) ? cnt_base + COUNTER_BITS'(1) : cnt_base;
        cnt_next  = differs ? cnt_inc : cnt_base;
        adopt     = differs && (CMP_W'(cnt_inc) >= CMP_W'(ticks));
        deb_next  = adopt ? raw : deb_reg;
    end

    // Lane state advances once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            cand_reg <= 1'b0;
            deb_reg  <= LVL_RELEASED;
        end
        else if (en)
        begin
            cnt_reg  <= cnt_next;
            cand_reg <= cand_next;
            deb_reg  <= deb_next;
        end
    end

    // The previous level is the debounced level held from the last tick.
    assign stat.level = deb_next;
    assign stat.prev  = deb_reg;

endmodule

[hdl/tbdcd_merge.sv]
// Merge stage: chord decoding of the three lanes and the power state update.
module tbdcd_merge
    import tbdcd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  lane_stat_t [BTN_COUNT-1:0]  lanes,
    input  logic [1:0]                  power_in,
    output tbdcd_out_t                  result
);

    logic sleep_armed_reg, sleep_armed_next;
    logic pwr_pressed, plus_pressed, minus_pressed;
    logic plus_edge, minus_edge, pwr_was_pressed;
    logic chord;
    logic [1:0] pwr;

    // Decode requests and move the power state.
    always_comb
    begin
        pwr_pressed     = (lanes[BTN_POWER].level == LVL_PRESSED);
        plus_pressed    = (lanes[BTN_PLUS].level == LVL_PRESSED);
        minus_pressed   = (lanes[BTN_MINUS].level == LVL_PRESSED);
        plus_edge       = plus_pressed && (lanes[BTN_PLUS].prev == LVL_RELEASED);
        minus_edge      = minus_pressed && (lanes[BTN_MINUS].prev == LVL_RELEASED);
        pwr_was_pressed = (lanes[BTN_POWER].prev == LVL_PRESSED);
        chord           = plus_pressed && minus_pressed && (plus_edge || minus_edge);

        sleep_armed_next   = sleep_armed_reg;
        result.bright_up   = 1'b0;
        result.bright_down = 1'b0;
        result.colour_next = 1'b0;
        result.output_next = 1'b0;
        pwr                = power_in;

        if (!pwr_pressed)
        begin
            if (!chord)
            begin
                result.bright_up   = plus_edge;
                result.bright_down = !plus_edge && minus_edge;
            end
        end
        else
        begin
            if (plus_pressed || minus_pressed)
            begin
                sleep_armed_next = 1'b0;
            end
            result.colour_next = plus_edge;
            result.output_next = minus_edge;
        end

        if ((pwr == PWR_PRE_ON) && pwr_pressed)
        begin
            pwr = PWR_ON;
        end

        // Power release edge: arm first, then a release while armed moves power from on to pre_off.
        if (!pwr_pressed && pwr_was_pressed)
        begin
            if (!sleep_armed_next)
            begin
                sleep_armed_next = 1'b1;
            end
            else if (pwr == PWR_ON)
            begin
                pwr              = PWR_PRE_OFF;
                sleep_armed_next = 1'b0;
            end
        end

        // Power button idle: arm while on, disarm once pre_off is reached.
        if (!pwr_pressed && !pwr_was_pressed)
        begin
            if ((pwr == PWR_ON) && !sleep_armed_next)
            begin
                sleep_armed_next = 1'b1;
            end
            if ((pwr == PWR_PRE_OFF) && sleep_armed_next)
            begin
                sleep_armed_next = 1'b0;
            end
        end

        result.power_out = pwr;
    end

    // Sleep arming flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_armed_reg <= 1'b0;
        end
        else if (en)
        begin
            sleep_armed_reg <= sleep_armed_next;
        end
    end

endmodule

[hdl/three_button_debounce_chord_decoder.sv]
// An accepted input word's output word appears in the output register in the next cycle.
// Throughput: one word per cycle unless out_ready stalls the output; the three debounce
// lanes and merge logic are combinational, and one output register holds each result.
// Reset (rst_n low, asynchronous): counters and candidates clear, debounced levels
// read released, sleep flag clears, threshold returns to 10, no output word pending.
module three_button_debounce_chord_decoder
    import tbdcd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  tbdcd_in_t          in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tbdcd_out_t         out_data
);

    logic [TICKS_W-1:0]         ticks_reg;
    logic                       out_valid_reg, out_valid_next;
    tbdcd_out_t                 out_data_reg;
    tbdcd_out_t                 result;
    logic                       accept;
    logic [BTN_COUNT-1:0]       raw_vec;
    lane_stat_t [BTN_COUNT-1:0] lanes;

    // Handshake: take a new word whenever the output register is free or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        out_valid_next = accept || (out_valid_reg && !out_ready);
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= DEBOUNCE_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            ticks_reg <= cfg_data;
        end
    end

    // Raw levels in lane order.
    assign raw_vec[BTN_POWER] = in_data.raw_power_button;
    assign raw_vec[BTN_PLUS]  = in_data.raw_plus_button;
    assign raw_vec[BTN_MINUS] = in_data.raw_minus_button;

    // One debounce lane per button.
    for (genvar b = 0; b < BTN_COUNT; b++)
    begin : g_lane
        tbdcd_lane #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .raw   (raw_vec[b]),
            .ticks (ticks_reg),
            .stat  (lanes[b])
        );
    end

    // Merge of the lane results.
    tbdcd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .lanes    (lanes),
        .power_in (in_data.power_in),
        .result   (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/tbdcd_checker.sv]
// Port-level checker of the three-button debounce chord decoder and its bind.
`include "three_button_debounce_chord_decoder_defines.svh"

module tbdcd_checker
    import tbdcd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input tbdcd_in_t  in_data,
    input logic       out_valid,
    input logic       out_ready,
    input tbdcd_out_t out_data
);

    logic bright_req;
    logic held_req;
    logic in_off;

    // Request groups of the output word and the off state of the input word.
    assign bright_req = out_data.bright_up || out_data.bright_down;
    assign held_req   = out_data.colour_next || out_data.output_next;
    assign in_off     = (in_data.power_in == PWR_OFF);

    // A stalled output word stays valid and unchanged.
    `TBDCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Brightness up and down are never requested together.
    `TBDCD_ASSERT_NOW(a_bright_excl, out_valid, !(out_data.bright_up && out_data.bright_down))

    // Brightness requests and power-held requests never share a word.
    `TBDCD_ASSERT_NOW(a_group_excl, out_valid && bright_req, !held_req)

    // An accepted word in the off state comes out next cycle still off.
    `TBDCD_ASSERT_NEXT(a_off_pass, in_valid && in_ready && in_off, out_valid && (out_data.power_out == PWR_OFF))

endmodule

bind three_button_debounce_chord_decoder tbdcd_checker u_tbdcd_checker (.*);
